// File: rtl/core/dtq_pkg.sv
// package: shared types, widths and codes for the deadline timer queue
`timescale 1ns / 1ps

package dtq_pkg;

    // field widths fixed by the item formats
    localparam int unsigned TIME_BITS   = 32;
    localparam int unsigned TAG_BITS    = 16;
    localparam int unsigned HANDLE_BITS = 4;

    // table size default and the cap on results from one tick
    localparam int unsigned SLOTS_DEFAULT = 16;
    localparam int unsigned MAX_RESULTS   = 16;

    // request kinds
    typedef enum logic [1:0] {
        REQ_SUBMIT_ABS = 2'd0,
        REQ_SUBMIT_REL = 2'd1,
        REQ_CANCEL     = 2'd2,
        REQ_TICK       = 2'd3
    } req_kind_t;

    // result kinds
    typedef enum logic [2:0] {
        RES_SUBMITTED   = 3'd0,
        RES_TABLE_FULL  = 3'd1,
        RES_CANCELLED   = 3'd2,
        RES_NOT_PENDING = 3'd3,
        RES_FIRED       = 3'd4,
        RES_NONE_DUE    = 3'd5
    } res_kind_t;

    // request item
    typedef struct packed {
        req_kind_t              req_type;
        logic [TIME_BITS-1:0]   time_value;
        logic [TAG_BITS-1:0]    action_tag;
        logic [HANDLE_BITS-1:0] handle;
    } req_item_t;

    // result item
    typedef struct packed {
        res_kind_t              result_kind;
        logic [HANDLE_BITS-1:0] out_handle;
        logic [TAG_BITS-1:0]    fired_tag;
        logic                   last_of_run;
    } rsp_item_t;

    // one table entry
    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [TAG_BITS-1:0]  tag;
    } slot_entry_t;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic valid;
    } scan_ctrl_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SUBMIT,
        S_CANCEL,
        S_SCAN,
        S_EMIT,
        S_FLUSH
    } state_t;

endpackage

// File: rtl/core/dtq_min_unit.sv
// shared compare unit: tracks the earliest due entry over one table scan
`timescale 1ns / 1ps

module dtq_min_unit #(
    parameter int unsigned SLOTS = dtq_pkg::SLOTS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dtq_pkg::scan_ctrl_t            ctrl,
    input  logic                           cand_pending,
    input  logic [$clog2(SLOTS)-1:0]       cand_idx,
    input  dtq_pkg::slot_entry_t           cand,
    input  logic [dtq_pkg::TIME_BITS-1:0]  now,
    output logic                           best_found,
    output logic [$clog2(SLOTS)-1:0]       best_idx,
    output logic [dtq_pkg::TAG_BITS-1:0]   best_tag
);
    import dtq_pkg::*;

    localparam int unsigned IDX_W = $clog2(SLOTS);

    logic                 found_reg;
    logic                 found_next;
    logic [TIME_BITS-1:0] best_dl_reg;
    logic [TIME_BITS-1:0] best_dl_next;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [IDX_W-1:0]     best_idx_next;
    logic [TAG_BITS-1:0]  best_tag_reg;
    logic [TAG_BITS-1:0]  best_tag_next;
    logic                 take;

    // candidate wins if pending, due, and strictly earlier than the current best
    assign take = ctrl.valid && cand_pending && (cand.deadline <= now)
                  && (!found_reg || (cand.deadline < best_dl_reg));

    always_comb
    begin
        found_next    = found_reg;
        best_dl_next  = best_dl_reg;
        best_idx_next = best_idx_reg;
        best_tag_next = best_tag_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next    = 1'b1;
            best_dl_next  = cand.deadline;
            best_idx_next = cand_idx;
            best_tag_next = cand.tag;
        end
    end

    // found flag is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    // best entry payload
    always_ff @(posedge clk)
    begin
        best_dl_reg  <= best_dl_next;
        best_idx_reg <= best_idx_next;
        best_tag_reg <= best_tag_next;
    end

    assign best_found = found_reg;
    assign best_idx   = best_idx_reg;
    assign best_tag   = best_tag_reg;

endmodule

// File: rtl/core/deadline_timer_queue.sv
// Submit and cancel register their result in S_SUBMIT or S_CANCEL once the output register is free,
// and the next item is taken after the return to S_IDLE.
// A tick that fires k entries runs k+1 table scans (16 scans and a flush state at k = 16),
// each one slot read per cycle, then a last compare, a done step and the emit state.
// One item at a time: req_stall stays high until the last result is registered.
// Reset clears the pending flags, the last tick time and all control state, not the memory.
`timescale 1ns / 1ps

module deadline_timer_queue #(
    parameter int unsigned SLOTS = dtq_pkg::SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  dtq_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output dtq_pkg::rsp_item_t rsp
);
    import dtq_pkg::*;

    localparam int unsigned IDX_W = $clog2(SLOTS);
    localparam int unsigned CNT_W = $clog2(SLOTS + 1);
    localparam int unsigned RC_W  = $clog2(MAX_RESULTS + 1);
    localparam int unsigned HX_W  = IDX_W + HANDLE_BITS;

    // slot memory and its registered read port
    slot_entry_t mem [SLOTS];
    slot_entry_t rd_data_reg;

    state_t               state_reg;
    state_t               state_next;
    req_item_t            req_reg;
    req_item_t            req_next;
    logic [TIME_BITS-1:0] last_tick_reg;
    logic [TIME_BITS-1:0] last_tick_next;
    logic [SLOTS-1:0]     pending_reg;
    logic [SLOTS-1:0]     pending_next;
    logic [CNT_W-1:0]     rd_cnt_reg;
    logic [CNT_W-1:0]     rd_cnt_next;
    logic                 cmp_v_reg;
    logic                 cmp_v_next;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [IDX_W-1:0]     cmp_idx_next;
    logic                 held_valid_reg;
    logic                 held_valid_next;
    logic [IDX_W-1:0]     held_idx_reg;
    logic [IDX_W-1:0]     held_idx_next;
    logic [TAG_BITS-1:0]  held_tag_reg;
    logic [TAG_BITS-1:0]  held_tag_next;
    logic [RC_W-1:0]      fired_cnt_reg;
    logic [RC_W-1:0]      fired_cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    rsp_item_t            out_item_reg;
    rsp_item_t            out_item_next;

    logic                 req_take;
    logic                 out_free;
    logic                 scan_done;
    logic                 last_claim;
    logic [RC_W-1:0]      cnt_inc;
    logic                 mem_we;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    slot_entry_t          wr_entry;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic [TIME_BITS:0]   rel_sum;
    logic [TIME_BITS-1:0] sub_deadline;
    logic [HX_W-1:0]      cancel_hx;
    logic [IDX_W-1:0]     cancel_idx;
    logic                 cancel_hit;
    scan_ctrl_t           scan_ctrl;
    logic                 best_found;
    logic [IDX_W-1:0]     best_idx;
    logic [TAG_BITS-1:0]  best_tag;

    assign req_take  = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign scan_done = (rd_cnt_reg == CNT_W'(SLOTS)) && !cmp_v_reg;
    assign cnt_inc   = fired_cnt_reg + RC_W'(1);
    assign last_claim = (cnt_inc == RC_W'(MAX_RESULTS));

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!pending_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // deadline of a submit, relative form saturates at the largest time
    assign rel_sum = {1'b0, last_tick_reg} + {1'b0, req_reg.time_value};
    always_comb
    begin
        if (req_reg.req_type == REQ_SUBMIT_REL)
        begin
            sub_deadline = rel_sum[TIME_BITS] ? '1 : rel_sum[TIME_BITS-1:0];
        end
        else
        begin
            sub_deadline = req_reg.time_value;
        end
    end

    // cancel target lookup
    assign cancel_hx  = HX_W'(req_reg.handle);
    assign cancel_idx = cancel_hx[IDX_W-1:0];
    assign cancel_hit = (cancel_hx < HX_W'(SLOTS)) && pending_reg[cancel_idx];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    unique case (req.req_type)
                        REQ_SUBMIT_ABS, REQ_SUBMIT_REL: state_next = S_SUBMIT;
                        REQ_CANCEL:                     state_next = S_CANCEL;
                        REQ_TICK:                       state_next = S_SCAN;
                        default:                        state_next = S_IDLE;
                    endcase
                end
            end
            S_SUBMIT, S_CANCEL, S_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (!best_found)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (last_claim)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath control and register updates
    always_comb
    begin
        req_next        = req_reg;
        last_tick_next  = last_tick_reg;
        pending_next    = pending_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_v_next      = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        held_tag_next   = held_tag_reg;
        fired_cnt_next  = fired_cnt_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_item_next   = out_item_reg;
        mem_we          = 1'b0;
        wr_entry        = '{deadline: sub_deadline, tag: req_reg.action_tag};
        rd_en           = 1'b0;
        rd_addr         = rd_cnt_reg[IDX_W-1:0];
        scan_ctrl       = '{clear: 1'b0, valid: 1'b0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    req_next = req;
                    if (req.req_type == REQ_TICK)
                    begin
                        last_tick_next  = req.time_value;
                        held_valid_next = 1'b0;
                        fired_cnt_next  = '0;
                        rd_cnt_next     = '0;
                        scan_ctrl.clear = 1'b1;
                    end
                end
            end
            S_SUBMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (free_found)
                    begin
                        mem_we                 = 1'b1;
                        pending_next[free_idx] = 1'b1;
                        out_item_next = '{result_kind: RES_SUBMITTED,
                                          out_handle: HANDLE_BITS'(free_idx),
                                          fired_tag: '0, last_of_run: 1'b1};
                    end
                    else
                    begin
                        out_item_next = '{result_kind: RES_TABLE_FULL, out_handle: '0,
                                          fired_tag: '0, last_of_run: 1'b1};
                    end
                end
            end
            S_CANCEL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (cancel_hit)
                    begin
                        pending_next[cancel_idx] = 1'b0;
                        out_item_next = '{result_kind: RES_CANCELLED,
                                          out_handle: req_reg.handle,
                                          fired_tag: '0, last_of_run: 1'b1};
                    end
                    else
                    begin
                        out_item_next = '{result_kind: RES_NOT_PENDING,
                                          out_handle: req_reg.handle,
                                          fired_tag: '0, last_of_run: 1'b1};
                    end
                end
            end
            S_SCAN:
            begin
                // one slot read per cycle, compared in the cycle after its read
                scan_ctrl.valid = cmp_v_reg;
                if (rd_cnt_reg != CNT_W'(SLOTS))
                begin
                    rd_en        = 1'b1;
                    rd_cnt_next  = rd_cnt_reg + CNT_W'(1);
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = rd_cnt_reg[IDX_W-1:0];
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (best_found)
                    begin
                        // emit the held entry, not last since another is due
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_item_next = '{result_kind: RES_FIRED,
                                              out_handle: HANDLE_BITS'(held_idx_reg),
                                              fired_tag: held_tag_reg,
                                              last_of_run: 1'b0};
                        end
                        // claim the new earliest entry and rescan
                        held_valid_next        = 1'b1;
                        held_idx_next          = best_idx;
                        held_tag_next          = best_tag;
                        pending_next[best_idx] = 1'b0;
                        fired_cnt_next         = cnt_inc;
                        rd_cnt_next            = '0;
                        scan_ctrl.clear        = 1'b1;
                    end
                    else if (held_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_item_next = '{result_kind: RES_FIRED,
                                          out_handle: HANDLE_BITS'(held_idx_reg),
                                          fired_tag: held_tag_reg, last_of_run: 1'b1};
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_item_next = '{result_kind: RES_NONE_DUE, out_handle: '0,
                                          fired_tag: '0, last_of_run: 1'b1};
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next = '{result_kind: RES_FIRED,
                                      out_handle: HANDLE_BITS'(held_idx_reg),
                                      fired_tag: held_tag_reg, last_of_run: 1'b1};
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && rsp_stall;
            end
        endcase
    end

    // slot memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[free_idx] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_tick_reg  <= '0;
            pending_reg    <= '0;
            rd_cnt_reg     <= '0;
            cmp_v_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            fired_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_tick_reg  <= last_tick_next;
            pending_reg    <= pending_next;
            rd_cnt_reg     <= rd_cnt_next;
            cmp_v_reg      <= cmp_v_next;
            held_valid_reg <= held_valid_next;
            fired_cnt_reg  <= fired_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        cmp_idx_reg  <= cmp_idx_next;
        held_idx_reg <= held_idx_next;
        held_tag_reg <= held_tag_next;
        out_item_reg <= out_item_next;
    end

    // shared compare unit
    dtq_min_unit #(
        .SLOTS (SLOTS)
    ) u_min (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (scan_ctrl),
        .cand_pending (pending_reg[cmp_idx_reg]),
        .cand_idx     (cmp_idx_reg),
        .cand         (rd_data_reg),
        .now          (last_tick_reg),
        .best_found   (best_found),
        .best_idx     (best_idx),
        .best_tag     (best_tag)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

endmodule

// File: sim/deadline_timer_queue_tb.sv
// testbench: deadline timer queue checked item by item against an in-bench timer table
`timescale 1ns / 1ps

module deadline_timer_queue_tb;
    import dtq_pkg::*;

    localparam int unsigned SLOTS        = SLOTS_DEFAULT;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned STUCK_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES = 40;

    // one pending request plus the traffic shape it goes out with
    typedef struct {
        req_item_t   item;
        int unsigned tx_idle;
        int unsigned rx_idle;
        bit          drain;
        bit          hold_rx;
    } timer_req_entry_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    req_item_t  req = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    rsp_item_t  rsp;

    timer_req_entry_t pending_reqs[$];
    rsp_item_t        expected_timer_results[$];

    // shadow timer table
    logic [TIME_BITS-1:0] shadow_deadline[SLOTS];
    logic [TAG_BITS-1:0]  shadow_tag[SLOTS];
    logic                 shadow_pending[SLOTS];
    logic [TIME_BITS-1:0] shadow_tick_time = '0;

    // stimulus shaping state
    int unsigned          cur_tx_idle = 0;
    int unsigned          cur_rx_idle = 0;
    bit                   drain_next = 1'b0;
    bit                   hold_next = 1'b0;
    logic [TIME_BITS-1:0] gen_now = '0;

    // driver and receiver state
    timer_req_entry_t drv_next;
    bit               drv_go;
    int unsigned      rx_idle_pct = 0;
    bit               hold_toggle = 1'b0;
    bit               hold_seen = 1'b0;
    int unsigned      hold_cnt = 0;

    int unsigned mismatch_cnt = 0;
    int unsigned stuck_cnt = 0;

    deadline_timer_queue #(.SLOTS(SLOTS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_pending[i] = 1'b0;
            shadow_deadline[i] = '0;
            shadow_tag[i] = '0;
        end
    end

    // work out the result items one request causes and update the shadow table
    function automatic void predict_timer_results(req_item_t it);
        rsp_item_t            r;
        rsp_item_t            prev;
        logic [TIME_BITS:0]   sum;
        logic [TIME_BITS-1:0] dl;
        bit                   placed;
        bit                   have_prev;
        int                   best;
        int unsigned          n;

        r = '0;
        r.last_of_run = 1'b1;
        case (it.req_type)
            REQ_SUBMIT_ABS, REQ_SUBMIT_REL:
            begin
                if (it.req_type == REQ_SUBMIT_ABS)
                    dl = it.time_value;
                else
                begin
                    // relative deadline saturates at the largest time
                    sum = {1'b0, shadow_tick_time} + {1'b0, it.time_value};
                    dl = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
                end
                r.result_kind = RES_TABLE_FULL;
                placed = 1'b0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!placed && !shadow_pending[i])
                    begin
                        placed = 1'b1;
                        shadow_pending[i] = 1'b1;
                        shadow_deadline[i] = dl;
                        shadow_tag[i] = it.action_tag;
                        r.result_kind = RES_SUBMITTED;
                        r.out_handle = i[HANDLE_BITS-1:0];
                    end
                end
                expected_timer_results.push_back(r);
            end
            REQ_CANCEL:
            begin
                r.out_handle = it.handle;
                if (it.handle < SLOTS && shadow_pending[it.handle])
                begin
                    shadow_pending[it.handle] = 1'b0;
                    r.result_kind = RES_CANCELLED;
                end
                else
                    r.result_kind = RES_NOT_PENDING;
                expected_timer_results.push_back(r);
            end
            default:
            begin
                // tick: fire due entries earliest deadline first, lower handle on ties
                shadow_tick_time = it.time_value;
                n = 0;
                have_prev = 1'b0;
                best = 0;
                while (n < MAX_RESULTS && best >= 0)
                begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (shadow_pending[i] && shadow_deadline[i] <= it.time_value
                            && (best < 0 || shadow_deadline[i] < shadow_deadline[best]))
                            best = i;
                    end
                    if (best >= 0)
                    begin
                        if (have_prev)
                            expected_timer_results.push_back(prev);
                        shadow_pending[best] = 1'b0;
                        prev = '0;
                        prev.result_kind = RES_FIRED;
                        prev.out_handle = best[HANDLE_BITS-1:0];
                        prev.fired_tag = shadow_tag[best];
                        have_prev = 1'b1;
                        n++;
                    end
                end
                if (have_prev)
                begin
                    prev.last_of_run = 1'b1;
                    expected_timer_results.push_back(prev);
                end
                else
                begin
                    r.result_kind = RES_NONE_DUE;
                    expected_timer_results.push_back(r);
                end
            end
        endcase
    endfunction

    function automatic void queue_timer_req(req_kind_t k, logic [TIME_BITS-1:0] tv,
                                            logic [TAG_BITS-1:0] tag,
                                            logic [HANDLE_BITS-1:0] h);
        timer_req_entry_t e;

        e.item.req_type = k;
        e.item.time_value = tv;
        e.item.action_tag = tag;
        e.item.handle = h;
        e.tx_idle = cur_tx_idle;
        e.rx_idle = cur_rx_idle;
        e.drain = drain_next;
        e.hold_rx = hold_next;
        drain_next = 1'b0;
        hold_next = 1'b0;
        pending_reqs.push_back(e);
    endfunction

    // random traffic: bursts heavy in submits alternate with tick-heavy stretches
    function automatic void queue_random_timer_reqs(int unsigned count);
        int unsigned          sel;
        int unsigned          submit_pct;
        logic [TIME_BITS-1:0] tv;

        for (int unsigned i = 0; i < count; i++)
        begin
            submit_pct = ((i / 25) % 2 == 0) ? 70 : 35;
            sel = $urandom_range(99);
            if (sel < submit_pct)
            begin
                if ($urandom_range(1) == 0)
                begin
                    tv = ($urandom_range(11) == 0) ? $urandom : gen_now + $urandom_range(200);
                    queue_timer_req(REQ_SUBMIT_ABS, tv, TAG_BITS'($urandom_range(16'hFFFF)),
                                    HANDLE_BITS'($urandom_range(15)));
                end
                else
                begin
                    tv = ($urandom_range(11) == 0) ? $urandom : $urandom_range(200);
                    queue_timer_req(REQ_SUBMIT_REL, tv, TAG_BITS'($urandom_range(16'hFFFF)),
                                    HANDLE_BITS'($urandom_range(15)));
                end
            end
            else if (sel < submit_pct + 15)
                queue_timer_req(REQ_CANCEL, $urandom, TAG_BITS'($urandom_range(16'hFFFF)),
                                HANDLE_BITS'($urandom_range(15)));
            else
            begin
                // mostly forward time, sometimes a jump or a step back
                if ($urandom_range(19) == 0)
                    gen_now = $urandom;
                else if ($urandom_range(9) == 0)
                    gen_now = gen_now - $urandom_range(50);
                else
                    gen_now = gen_now + $urandom_range(150);
                queue_timer_req(REQ_TICK, gen_now, TAG_BITS'($urandom_range(16'hFFFF)),
                                HANDLE_BITS'($urandom_range(15)));
            end
        end
    endfunction

    // stimulus and end of run
    initial
    begin
        // first phase: sender idles often, receiver stalls more often
        cur_tx_idle = 38;
        cur_rx_idle = 66;

        // directed: empty table, free-slot cancel, saturation, ties, full table
        queue_timer_req(REQ_TICK, 32'h0000_0000, 16'h0000, 4'h0);
        queue_timer_req(REQ_CANCEL, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
        queue_timer_req(REQ_TICK, 32'h0000_0010, 16'h0000, 4'h0);
        queue_timer_req(REQ_SUBMIT_ABS, 32'h0000_0000, 16'hFFFF, 4'hF);
        queue_timer_req(REQ_SUBMIT_ABS, 32'hFFFF_FFFF, 16'h0000, 4'h0);
        queue_timer_req(REQ_SUBMIT_REL, 32'h0000_0000, 16'h0001, 4'h0);
        queue_timer_req(REQ_SUBMIT_REL, 32'hFFFF_FFFF, 16'h0002, 4'h0);
        queue_timer_req(REQ_SUBMIT_ABS, 32'h0000_0010, 16'h0003, 4'h0);
        for (int unsigned k = 0; k < 11; k++)
            queue_timer_req(REQ_SUBMIT_ABS, 32'h0100_0000 * (k % 6) + 32'h55AA,
                            TAG_BITS'(16'h0100 + k), 4'h0);
        queue_timer_req(REQ_SUBMIT_REL, 32'h0000_0005, 16'h0BAD, 4'h0);
        queue_timer_req(REQ_CANCEL, 32'h0, 16'h0, 4'h3);
        queue_timer_req(REQ_CANCEL, 32'h0, 16'h0, 4'h3);
        queue_timer_req(REQ_TICK, 32'hFFFF_FFFE, 16'h0000, 4'h0);
        queue_timer_req(REQ_TICK, 32'hFFFF_FFFF, 16'h0000, 4'h0);
        queue_timer_req(REQ_TICK, 32'h0000_0005, 16'h0000, 4'h0);

        gen_now = 32'h0000_0005;
        queue_random_timer_reqs(100);

        // second phase: roles swapped, sender waits for all earlier results before the first item
        cur_tx_idle = 66;
        cur_rx_idle = 38;
        drain_next = 1'b1;
        queue_random_timer_reqs(100);

        // third phase: no idling, receiver holds off long while items keep coming
        cur_tx_idle = 0;
        cur_rx_idle = 0;
        drain_next = 1'b1;
        hold_next = 1'b1;
        queue_random_timer_reqs(105);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_timer_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && expected_timer_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            drv_go = pending_reqs.size() != 0;
            if (drv_go && pending_reqs[0].drain
                && (req_valid || expected_timer_results.size() != 0))
                drv_go = 1'b0;
            if (drv_go && $urandom_range(99) < pending_reqs[0].tx_idle)
                drv_go = 1'b0;
            if (drv_go)
            begin
                drv_next = pending_reqs.pop_front();
                req <= drv_next.item;
                rx_idle_pct <= drv_next.rx_idle;
                if (drv_next.hold_rx)
                    hold_toggle <= ~hold_toggle;
            end
            req_valid <= drv_go;
        end
    end

    // result stall: long hold when asked, random otherwise
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_cnt <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_cnt <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // predict on accepted requests, compare accepted results
    always @(posedge clk)
    begin
        rsp_item_t want;

        if (rst_n && req_valid && !req_stall)
            predict_timer_results(req);
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_timer_results.size() == 0)
            begin
                $error("unexpected result item: kind %0d handle %0d tag %0h last %0b",
                       rsp.result_kind, rsp.out_handle, rsp.fired_tag, rsp.last_of_run);
                mismatch_cnt++;
            end
            else
            begin
                want = expected_timer_results.pop_front();
                if (rsp.result_kind !== want.result_kind)
                begin
                    $error("result_kind: expected %0d, actual %0d",
                           want.result_kind, rsp.result_kind);
                    mismatch_cnt++;
                end
                if (rsp.out_handle !== want.out_handle)
                begin
                    $error("out_handle: expected %0d, actual %0d",
                           want.out_handle, rsp.out_handle);
                    mismatch_cnt++;
                end
                if (rsp.fired_tag !== want.fired_tag)
                begin
                    $error("fired_tag: expected %0h, actual %0h",
                           want.fired_tag, rsp.fired_tag);
                    mismatch_cnt++;
                end
                if (rsp.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0b, actual %0b",
                           want.last_of_run, rsp.last_of_run);
                    mismatch_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                stuck_cnt <= 0;
            else if (stuck_cnt + 1 >= STUCK_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                stuck_cnt <= stuck_cnt + 1;
        end
    end

endmodule
